/* rtl/nlp_pkg.sv */
package nlp_pkg;

  localparam int unsigned NumModesDef = 3;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CalW     = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned SampleW  = 7;
  localparam int unsigned TargetW  = 16;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned GainW    = 24;
  localparam int unsigned DriveW   = 16;

  localparam int unsigned FracBits = 14;
  localparam int unsigned QuoW     = LevelW + FracBits;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam int unsigned ErrW    = 19;
  localparam int unsigned IntegW  = 32;
  localparam int unsigned MulBW   = 32;
  localparam int unsigned ProdW   = GainW + MulBW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned DriveSh = 18;

  localparam logic [CfgIdxW-1:0] RegCalMode0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCalMode1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCalMode2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainP    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGainI    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGainD    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEdgeR    = 3'd6;

  localparam logic [CalW-1:0] CalReset = 16'd25600;

  localparam logic signed [AccW-1:0] PidMax = AccW'(64'sd100 <<< 26);

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SET,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     err_upd;
    logic     integ_upd;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     out_load;
  } nlp_cmd_t;

endpackage

/* rtl/nlp_ctrl.sv */
module nlp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_stall_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output nlp_pkg::nlp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_ERR,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_OUT
  } state_e;

  state_e                            state_q;
  logic   [nlp_pkg::DivCntW-1:0]     cnt_q;
  logic                              out_valid_q;
  logic                              out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = nlp_pkg::MUL_P;
    cmd_o.acc_op   = nlp_pkg::ACC_HOLD;
    unique case (state_q)
      S_IDLE:  cmd_o.load = in_valid_i;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_ERR:   cmd_o.err_upd = 1'b1;
      S_INTEG: cmd_o.integ_upd = 1'b1;
      S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = nlp_pkg::MUL_P;
      end
      S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = nlp_pkg::MUL_I;
        cmd_o.acc_op  = nlp_pkg::ACC_SET;
      end
      S_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = nlp_pkg::MUL_D;
        cmd_o.acc_op  = nlp_pkg::ACC_ADD;
      end
      S_ACC:   cmd_o.acc_op = nlp_pkg::ACC_ADD;
      S_OUT:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end
        end
        S_DIV: begin
          if (cnt_q == nlp_pkg::DivCntW'(nlp_pkg::DivSteps - 1)) begin
            state_q <= S_ERR;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ERR:   state_q <= S_INTEG;
        S_INTEG: state_q <= S_MUL_P;
        S_MUL_P: state_q <= S_MUL_I;
        S_MUL_I: state_q <= S_MUL_D;
        S_MUL_D: state_q <= S_ACC;
        S_ACC:   state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/nlp_datapath.sv */
module nlp_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  nlp_pkg::nlp_cmd_t                      cmd_i,
  input  logic        [nlp_pkg::CalW-1:0]        cal_word_i,
  input  logic        [nlp_pkg::SampleW-1:0]     sample_i,
  input  logic signed [nlp_pkg::TargetW-1:0]     target_i,
  input  logic signed [nlp_pkg::GainW-1:0]       gain_p_i,
  input  logic signed [nlp_pkg::GainW-1:0]       gain_i_i,
  input  logic signed [nlp_pkg::GainW-1:0]       gain_d_i,
  input  logic                                   edge_right_i,
  output logic signed [nlp_pkg::DriveW-1:0]      drive_o,
  output logic                                   cal_error_o
);

  localparam int unsigned LW = nlp_pkg::LevelW;
  localparam int unsigned QW = nlp_pkg::QuoW;
  localparam int unsigned EW = nlp_pkg::ErrW;
  localparam int unsigned IW = nlp_pkg::IntegW;
  localparam int unsigned AW = nlp_pkg::AccW;

  localparam logic signed [QW+1:0] ErrMax = (QW+2)'((64'sd1 <<< (EW - 1)) - 1);
  localparam logic signed [QW+1:0] ErrMin = (QW+2)'(-(64'sd1 <<< (EW - 1)));
  localparam logic signed [IW:0]   IntMax = (IW+1)'((64'sd1 <<< (IW - 1)) - 1);
  localparam logic signed [IW:0]   IntMin = (IW+1)'(-(64'sd1 <<< (IW - 1)));

  // load and divider setup
  logic        [LW-1:0]  black, white;
  logic signed [LW:0]    num_s, den_s;
  logic        [LW-1:0]  num_mag, den_mag;

  logic signed [nlp_pkg::TargetW-1:0] target_q;
  logic                  cal_err_q;
  logic                  neg_q;
  logic        [LW-1:0]  den_q;
  logic        [LW-1:0]  rem_q;
  logic        [QW-1:0]  quo_q;

  logic        [LW:0]    shifted;
  logic        [LW+1:0]  trial;

  // error and integral
  logic signed [QW:0]    norm;
  logic signed [QW+1:0]  diff_wide;
  logic signed [EW-1:0]  err_d;
  logic signed [EW-1:0]  err_q, prev_error_q;
  logic signed [EW:0]    delta_q, sum_q;
  logic signed [EW-1:0]  half;
  logic signed [IW:0]    integ_wide;
  logic signed [IW-1:0]  integral_q;

  // multiply and accumulate
  logic signed [nlp_pkg::GainW-1:0]  mul_a;
  logic signed [nlp_pkg::MulBW-1:0]  mul_b;
  logic signed [nlp_pkg::ProdW-1:0]  prod_q;
  logic signed [AW-1:0]              acc_q;
  logic signed [AW-1:0]              pid;
  logic signed [AW-1:0]              pid_sh;
  logic signed [nlp_pkg::DriveW-1:0] drive_raw;

  logic signed [nlp_pkg::DriveW-1:0] drive_q;
  logic                              cal_error_q;

  assign black   = cal_word_i[LW-1:0];
  assign white   = cal_word_i[2*LW-1:LW];
  assign num_s   = $signed({2'b00, sample_i}) - $signed({1'b0, black});
  assign den_s   = $signed({1'b0, white}) - $signed({1'b0, black});
  assign num_mag = num_s[LW] ? LW'(-num_s) : num_s[LW-1:0];
  assign den_mag = den_s[LW] ? LW'(-den_s) : den_s[LW-1:0];

  assign shifted = {rem_q, quo_q[QW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q  <= target_i;
      cal_err_q <= (den_s == '0);
      neg_q     <= num_s[LW] ^ den_s[LW];
      den_q     <= den_mag;
      rem_q     <= '0;
      quo_q     <= {num_mag, {nlp_pkg::FracBits{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= trial[LW+1] ? shifted[LW-1:0] : trial[LW-1:0];
      quo_q <= {quo_q[QW-2:0], ~trial[LW+1]};
    end
  end

  always_comb begin
    if (cal_err_q) begin
      norm = '0;
    end else if (neg_q) begin
      norm = -$signed({1'b0, quo_q});
    end else begin
      norm = $signed({1'b0, quo_q});
    end
    diff_wide = (QW+2)'(norm) - (QW+2)'(target_q);
    if (diff_wide > ErrMax) begin
      err_d = EW'(ErrMax);
    end else if (diff_wide < ErrMin) begin
      err_d = EW'(ErrMin);
    end else begin
      err_d = diff_wide[EW-1:0];
    end
  end

  // trapezoid step, rounded toward zero
  assign half = EW'((sum_q + (EW+1)'(sum_q[EW])) >>> 1);
  assign integ_wide = (IW+1)'(integral_q) + (IW+1)'(half);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_error_q <= '0;
      integral_q   <= '0;
    end else begin
      if (cmd_i.err_upd) begin
        prev_error_q <= err_d;
      end
      if (cmd_i.integ_upd) begin
        if (integ_wide > IntMax) begin
          integral_q <= IW'(IntMax);
        end else if (integ_wide < IntMin) begin
          integral_q <= IW'(IntMin);
        end else begin
          integral_q <= integ_wide[IW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_upd) begin
      err_q   <= err_d;
      delta_q <= (EW+1)'(err_d) - (EW+1)'(prev_error_q);
      sum_q   <= (EW+1)'(err_d) + (EW+1)'(prev_error_q);
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      nlp_pkg::MUL_I: begin
        mul_a = gain_i_i;
        mul_b = integral_q;
      end
      nlp_pkg::MUL_D: begin
        mul_a = gain_d_i;
        mul_b = nlp_pkg::MulBW'(delta_q);
      end
      default: begin
        mul_a = gain_p_i;
        mul_b = nlp_pkg::MulBW'(err_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.acc_op)
      nlp_pkg::ACC_SET: acc_q <= AW'(prod_q);
      nlp_pkg::ACC_ADD: acc_q <= acc_q + AW'(prod_q);
      default: ;
    endcase
  end

  always_comb begin
    if (acc_q > nlp_pkg::PidMax) begin
      pid = nlp_pkg::PidMax;
    end else if (acc_q < -nlp_pkg::PidMax) begin
      pid = -nlp_pkg::PidMax;
    end else begin
      pid = acc_q;
    end
    pid_sh    = pid >>> nlp_pkg::DriveSh;
    drive_raw = pid_sh[nlp_pkg::DriveW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      drive_q     <= edge_right_i ? drive_raw : -drive_raw;
      cal_error_q <= cal_err_q;
    end
  end

  assign drive_o     = drive_q;
  assign cal_error_o = cal_error_q;

endmodule

/* rtl/normalized_line_pid_core.sv */
// Line-following PID controller on a normalized reflectance error. Each beat
// on the input channel carries a sample, a Q2.14 target and a run mode that
// picks a black/white calibration pair; the result beat carries the clamped
// Q8.8 drive and a flag for equal calibration levels. One item is worked at a
// time: a bit-serial normalizing divider forms the ratio, and the P, I and D
// products go through one shared 24x32 multiplier in turn. A finished result
// waits in the output register while the next item is accepted. Write
// configuration registers only while the block is idle.
module normalized_line_pid_core #(
  parameter int unsigned NumModes = nlp_pkg::NumModesDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [nlp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic        [nlp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic        [nlp_pkg::SampleW-1:0]    reflect_sample_i,
  input  logic signed [nlp_pkg::TargetW-1:0]    target_i,
  input  logic        [nlp_pkg::ModeW-1:0]      run_mode_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [nlp_pkg::DriveW-1:0]     drive_o,
  output logic                                  cal_error_o
);

  logic        [nlp_pkg::CalW-1:0]  cal_q [NumModes];
  logic signed [nlp_pkg::GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic                             edge_right_q;
  logic        [nlp_pkg::CalW-1:0]  cal_sel;
  nlp_pkg::nlp_cmd_t                cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NumModes; m++) begin
        cal_q[m] <= nlp_pkg::CalReset;
      end
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      edge_right_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        nlp_pkg::RegCalMode0, nlp_pkg::RegCalMode1, nlp_pkg::RegCalMode2: begin
          for (int m = 0; m < NumModes; m++) begin
            if (cfg_index_i == nlp_pkg::CfgIdxW'(m)) begin
              cal_q[m] <= cfg_wdata_i[nlp_pkg::CalW-1:0];
            end
          end
        end
        nlp_pkg::RegGainP: gain_p_q <= cfg_wdata_i;
        nlp_pkg::RegGainI: gain_i_q <= cfg_wdata_i;
        nlp_pkg::RegGainD: gain_d_q <= cfg_wdata_i;
        nlp_pkg::RegEdgeR: edge_right_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // out of range modes fall back to the last pair
  always_comb begin
    cal_sel = cal_q[NumModes-1];
    for (int m = 0; m < NumModes - 1; m++) begin
      if (run_mode_i == nlp_pkg::ModeW'(m)) begin
        cal_sel = cal_q[m];
      end
    end
  end

  nlp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  nlp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cal_word_i   (cal_sel),
    .sample_i     (reflect_sample_i),
    .target_i     (target_i),
    .gain_p_i     (gain_p_q),
    .gain_i_i     (gain_i_q),
    .gain_d_i     (gain_d_q),
    .edge_right_i (edge_right_q),
    .drive_o      (drive_o),
    .cal_error_o  (cal_error_o)
  );

endmodule

/* rtl/nlp_checker.sv */
module nlp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [nlp_pkg::DriveW-1:0] drive_o
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o))
    else $error("stalled result beat changed");

  // drive stays within plus or minus 100
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o <= 16'sd25600) && (drive_o >= -16'sd25600))
    else $error("drive out of range");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a result appears only as the block goes idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised while busy");

endmodule

bind normalized_line_pid_core nlp_checker u_nlp_checker (.*);
